// ===== rtl/cpc_pkg.sv =====
// Shared types and constants for the coprime pair counter.
package cpc_pkg;
  localparam int MaxValue = 65536;
  localparam int IdxW = 17;
  localparam int CntW = 33;
  localparam int SumW = 40;
  localparam int MuW = 2;
  localparam int FacW = 17;

  localparam logic [MuW-1:0] MU_ZERO = 2'b00;
  localparam logic [MuW-1:0] MU_POS  = 2'b01;
  localparam logic [MuW-1:0] MU_NEG  = 2'b11;

  // one classified query handed from front to back
  typedef struct packed {
    logic [IdxW-1:0] a;
    logic [IdxW-1:0] b;
    logic [IdxW-1:0] c;
    logic [IdxW-1:0] d;
    logic            err;
  } query_t;

  localparam int QDepth = 2;
endpackage

// ===== rtl/coprime_pair_counter.sv =====
// Top level of the coprime pair counter.
//  channel | dir | fields
//  in_     | in  | tdata: first_low, first_high, second_low, second_high
//  out_    | out | tdata: pair_count, range_error
// After reset the back part clears and sieves its tables (65537 entries: clear,
// scan, marking, then one division per entry for mu); the queue still takes up
// to two queries meanwhile. A query walks k up to min(first_high, second_high)
// and runs four divisions on the one shared bit-serial divider only for the k
// with nonzero mu. A rejected query skips the sum. A stalled result holds the
// back part only.
module coprime_pair_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // first_low, first_high, second_low, second_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // pair_count, range_error
);
  logic q_valid, q_pop;
  cpc_pkg::query_t q_head;

  cpc_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_pop, .q_head);
  cpc_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_head,
    .out_tvalid, .out_tready, .out_tdata);
endmodule

// ===== rtl/cpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module cpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cpc_divider.sv =====
// Restoring divider, one quotient bit per cycle: q = n / k.
module cpc_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [cpc_pkg::IdxW-1:0] num,
  input  logic [cpc_pkg::IdxW-1:0] den,
  output logic                   done,
  output logic [cpc_pkg::IdxW-1:0] quo
);
  localparam int W = cpc_pkg::IdxW;
  logic [W-1:0] q_r, q_nxt;
  logic [W:0]   rem_r, rem_nxt;
  logic [W-1:0] den_r, den_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [W:0]   trial;

  assign quo  = q_r;
  assign done = busy_r && (cnt_r == 5'd0);
  assign trial = {rem_r[W-1:0], q_r[W-1]};

  // shift in one numerator bit per cycle
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den; cnt_nxt = 5'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = trial - {1'b0, den_r};
          q_nxt = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt = {q_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end
endmodule

// ===== rtl/cpc_front.sv =====
// Front part: input transfer, range checks, two-entry query queue.
module cpc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,
  output logic                 q_valid,
  input  logic                 q_pop,
  output cpc_pkg::query_t      q_head
);
  localparam int W = cpc_pkg::IdxW;
  cpc_pkg::query_t ent_r [cpc_pkg::QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  cpc_pkg::query_t cls;
  logic push;
  logic [W-1:0] a, b, c, d;

  assign a = in_tdata[W-1:0];
  assign b = in_tdata[2*W-1:W];
  assign c = in_tdata[3*W-1:2*W];
  assign d = in_tdata[4*W-1:3*W];

  // classify: zero bound, empty range, bound beyond table
  always_comb begin
    cls.a = a; cls.b = b; cls.c = c; cls.d = d;
    cls.err = (a == '0) || (b == '0) || (c == '0) || (d == '0) ||
              (a > b) || (c > d) ||
              (b > W'(cpc_pkg::MaxValue)) || (d > W'(cpc_pkg::MaxValue));
  end

  assign in_tready = (cnt_r != 2'(cpc_pkg::QDepth));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
    if (push) ent_r[wp_r] <= cls;
  end
endmodule

// ===== rtl/cpc_back.sv =====
// Back part: sieve at reset, then Moebius sum per query.
module cpc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  cpc_pkg::query_t         q_head,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [39:0]             out_tdata
);
  localparam int W = cpc_pkg::IdxW;
  localparam int Depth = cpc_pkg::MaxValue + 1;
  localparam logic [W-1:0] MaxI = W'(cpc_pkg::MaxValue);
  localparam int FacW = cpc_pkg::FacW;
  localparam int MuW = cpc_pkg::MuW;
  localparam int SumW = cpc_pkg::SumW;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_SCAN  = 14'b00000000000010,
    S_SCANW = 14'b00000000000100,
    S_MARKR = 14'b00000000001000,
    S_MARKW = 14'b00000000010000,
    S_MUA   = 14'b00000000100000,
    S_MUB   = 14'b00000001000000,
    S_MUC   = 14'b00000010000000,
    S_IDLE  = 14'b00000100000000,
    S_RD    = 14'b00001000000000,
    S_DIV   = 14'b00010000000000,
    S_MUL   = 14'b00100000000000,
    S_ACC   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [W-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [cpc_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [cpc_pkg::MuW-1:0] mu_r, mu_nxt;
  logic [W-1:0] t_r [4];
  logic [W-1:0] s1_r, s2_r;
  logic [2*W-1:0] prod_r;
  logic [1:0] ph_r, ph_nxt;
  logic [cpc_pkg::CntW-1:0] res_cnt_r;
  logic res_err_r, ov_r;
  cpc_pkg::query_t qr_r;
  logic [W-1:0] lim;

  // factor and Moebius stores
  logic f_we, m_we;
  logic [W-1:0] f_wa, f_ra, m_wa, m_ra;
  logic [cpc_pkg::FacW-1:0] f_wd, f_rd;
  logic [cpc_pkg::MuW-1:0] m_wd, m_rd;

  cpc_ram #(.Width(cpc_pkg::FacW), .Depth(Depth)) u_fac (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  cpc_ram #(.Width(cpc_pkg::MuW), .Depth(Depth)) u_mu (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  // shared divider
  logic d_start, d_done;
  logic [W-1:0] d_num, d_den, d_quo;
  cpc_divider u_div (.clk, .rst_n, .start(d_start), .num(d_num), .den(d_den),
    .done(d_done), .quo(d_quo));

  assign lim = (qr_r.b < qr_r.d) ? qr_r.b : qr_r.d;

  logic [2*W:0] pp;
  assign pp = (2*W+1)'(i_r) * (2*W+1)'(i_r);

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; p_nxt = p_r; sum_nxt = sum_r;
    mu_nxt = mu_r; ph_nxt = ph_r;
    f_we = 1'b0; f_wa = i_r; f_wd = '0; f_ra = i_r;
    m_we = 1'b0; m_wa = i_r; m_wd = cpc_pkg::MU_ZERO; m_ra = i_r;
    d_start = 1'b0; d_num = '0; d_den = i_r;
    q_pop = 1'b0;
    case (st_r)
      // zero the factor and mu stores, seeding entry 1 on the way
      S_CLR: begin
        f_we = 1'b1; f_wa = i_r; f_wd = (i_r == W'(1)) ? FacW'(1) : '0;
        m_we = 1'b1; m_wd = (i_r == W'(1)) ? cpc_pkg::MU_POS : cpc_pkg::MU_ZERO;
        if (i_r == MaxI) begin i_nxt = W'(2); st_nxt = S_SCAN; end
        else i_nxt = i_r + W'(1);
      end
      S_SCAN: st_nxt = S_SCANW;
      // prime found when entry still zero
      S_SCANW: begin
        if (f_rd == '0) begin
          f_we = 1'b1; f_wa = i_r; f_wd = FacW'(i_r);
          if (pp <= (2*W+1)'(cpc_pkg::MaxValue)) begin
            j_nxt = pp[W-1:0]; st_nxt = S_MARKR;
          end else if (i_r == MaxI) begin i_nxt = W'(2); st_nxt = S_MUA; end
          else begin i_nxt = i_r + W'(1); st_nxt = S_SCAN; end
        end else if (i_r == MaxI) begin i_nxt = W'(2); st_nxt = S_MUA; end
        else begin i_nxt = i_r + W'(1); st_nxt = S_SCAN; end
        f_ra = i_nxt;
      end
      S_MARKR: begin f_ra = j_r; st_nxt = S_MARKW; end
      S_MARKW: begin
        f_ra = j_r;
        if (f_rd == '0) begin f_we = 1'b1; f_wa = j_r; f_wd = FacW'(i_r); end
        if ({1'b0, j_r} + {1'b0, i_r} > (W+1)'(cpc_pkg::MaxValue)) begin
          if (i_r == MaxI) begin i_nxt = W'(2); st_nxt = S_MUA; end
          else begin i_nxt = i_r + W'(1); st_nxt = S_SCAN; end
        end else begin
          j_nxt = j_r + i_r; st_nxt = S_MARKR;
        end
      end
      // mu: read p, divide i by p, read factor and mu of quotient
      S_MUA: begin
        f_ra = i_r;
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          p_nxt = f_rd[W-1:0]; d_start = 1'b1; d_num = i_r; d_den = f_rd[W-1:0];
          ph_nxt = 2'd0; st_nxt = S_MUB;
        end
      end
      S_MUB: begin
        if (d_done) begin j_nxt = d_quo; st_nxt = S_MUC; ph_nxt = 2'd0; end
      end
      S_MUC: begin
        f_ra = j_r; m_ra = j_r;
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          m_we = 1'b1; m_wa = i_r;
          if (j_r > W'(1) && f_rd[W-1:0] == p_r) m_wd = cpc_pkg::MU_ZERO;
          else m_wd = MuW'(-m_rd);
          ph_nxt = 2'd0;
          if (i_r == MaxI) st_nxt = S_IDLE;
          else begin i_nxt = i_r + W'(1); st_nxt = S_MUA; end
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; sum_nxt = '0; i_nxt = W'(1);
          st_nxt = q_head.err ? S_OUT : S_RD;
        end
      end
      // per k: fetch mu, skip zeros
      S_RD: begin
        m_ra = i_r;
        if (i_r > lim) st_nxt = S_OUT;
        else if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          ph_nxt = 2'd0; mu_nxt = m_rd;
          if (m_rd == cpc_pkg::MU_ZERO) i_nxt = i_r + W'(1);
          else begin
            st_nxt = S_DIV; d_start = 1'b1; d_num = qr_r.b;
          end
        end
      end
      // four floor divisions in turn on one divider
      S_DIV: begin
        if (d_done) begin
          if (ph_r == 2'd3) begin ph_nxt = 2'd0; st_nxt = S_MUL; end
          else begin
            ph_nxt = ph_r + 2'd1; d_start = 1'b1;
            case (ph_r)
              2'd0: d_num = qr_r.a - W'(1);
              2'd1: d_num = qr_r.d;
              2'd2: d_num = qr_r.c - W'(1);
              default: d_num = '0;
            endcase
          end
        end
      end
      S_MUL: st_nxt = S_ACC;
      S_ACC: begin
        if (mu_r == cpc_pkg::MU_POS) sum_nxt = sum_r + SumW'(prod_r);
        else sum_nxt = sum_r - SumW'(prod_r);
        i_nxt = i_r + W'(1); st_nxt = S_RD;
      end
      S_OUT: begin
        if (!ov_r) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, res_err_r, res_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; i_r <= '0; ph_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; ph_r <= ph_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      else if (st_r == S_OUT && !ov_r) ov_r <= 1'b1;
    end
    j_r <= j_nxt; p_r <= p_nxt; sum_r <= sum_nxt; mu_r <= mu_nxt;
    if (q_pop) qr_r <= q_head;
    if (st_r == S_DIV && d_done) t_r[ph_r] <= d_quo;
    if (st_r == S_DIV && d_done && ph_r == 2'd3) begin
      s1_r <= t_r[0] - t_r[1];
      s2_r <= t_r[2] - d_quo;
    end
    if (st_r == S_MUL) prod_r <= (2*W)'(s1_r) * (2*W)'(s2_r);
    if (st_r == S_OUT && !ov_r) begin
      res_err_r <= qr_r.err;
      res_cnt_r <= (qr_r.err || sum_r[SumW-1]) ? '0 : sum_r[cpc_pkg::CntW-1:0];
    end
  end
endmodule

// ===== rtl/cpc_checker.sv =====
// Port-level checks for the coprime pair counter.
module cpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [71:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  // error results carry a zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[32:0] == '0) else $error("err count");
  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == '0) else $error("pad");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  // no output during reset recovery cycle
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("rst");
endmodule

bind coprime_pair_counter cpc_checker u_chk (.*);
